// ----- sv/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- sv/dgam_pkg.sv -----
package dgam_pkg;

  localparam int DefMaxV = 64;

  localparam int KindW   = 2;
  localparam int VertexW = 6;
  localparam int VcountW = 7;
  localparam int DegW    = 7;
  localparam int TotalW  = 8;
  localparam int EdgeW   = 13;

  localparam logic [VcountW-1:0] VcountReset = 7'd64;

  typedef enum logic [KindW-1:0] {
    KIND_INSERT,
    KIND_REMOVE,
    KIND_QUERY,
    KIND_DEGREE
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_INVALID,
    STATUS_EXISTS,
    STATUS_ABSENT
  } status_e;

endpackage

// ----- sv/directed_graph_adjacency_matrix_core.sv -----
// Directed graph kept as a MAX_V by MAX_V bit matrix, one memory row per
// source vertex, plus an edge count.
// Command channel: an item (kind, src_vertex, dst_vertex) transfers at a
// rising edge with start_i high and busy_o low. Each item gives one result,
// shown for exactly one cycle with done_o high; the receiver cannot stall.
// Insert, remove and adjacency query: the source row is read at the transfer
// edge, then the block is busy in ST_ROW (update and write back); done_o is
// high once it is back in ST_IDLE, and only then can a new item transfer.
// Degree query: after the row read of the vertex, the block walks rows 0 to
// n-1 (n = min(vertex_count, MAX_V)) through the single memory read port,
// one row per cycle in ST_WALK, and done_o follows at once when the walk
// ends; a new item transfers only once the block is back in ST_IDLE.
// Configuration: cfg_data_i transfers at a rising edge with cfg_valid_i and
// cfg_ready_o high; write it only while the block is idle. The count in use
// is sampled when an item transfers.
// Reset: the matrix reads as empty at once (per-row valid bits, no clearing
// pass), the edge count is zero and vertex_count is 64.
module directed_graph_adjacency_matrix_core import dgam_pkg::*; #(
  parameter int MAX_V = DefMaxV
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [VertexW-1:0] src_vertex_i,
  input  logic [VertexW-1:0] dst_vertex_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [VcountW-1:0] cfg_data_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic               is_adjacent_o,
  output logic [DegW-1:0]    in_degree_o,
  output logic [DegW-1:0]    out_degree_o,
  output logic [TotalW-1:0]  total_degree_o,
  output logic [EdgeW-1:0]   edge_count_o
);

  `include "assert_macros.svh"

  localparam int IW   = $clog2(MAX_V);
  localparam int NW   = $clog2(MAX_V + 1);
  localparam int CMPW = (NW > VcountW) ? NW : VcountW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_WALK
  } state_e;

  state_e               state_q;
  kind_e                kind_q;
  logic [VertexW-1:0]   src_q;
  logic [VertexW-1:0]   dst_q;
  logic                 ok_q;
  logic [NW-1:0]        n_q;
  logic [IW-1:0]        idx_q;
  logic [NW-1:0]        din_q;
  logic [NW-1:0]        dout_q;
  logic [MAX_V-1:0]     row_q;
  logic [VcountW-1:0]   vcount_q;
  logic [EdgeW-1:0]     edge_q;
  logic                 done_q;
  status_e              status_q;
  logic                 adj_q;
  logic [DegW-1:0]      in_deg_q;
  logic [DegW-1:0]      out_deg_q;
  logic [TotalW-1:0]    total_q;

  logic [CMPW-1:0]      vc_ext;
  logic [CMPW-1:0]      max_ext;
  logic [CMPW-1:0]      n_cur;
  logic                 src_ok;
  logic                 dst_ok;
  logic [IW-1:0]        src_idx;
  logic [IW-1:0]        dst_idx;
  logic [IW-1:0]        rd_addr;
  logic [MAX_V-1:0]     rd_row;
  logic                 edge_bit;
  logic                 wr_en;
  logic [MAX_V-1:0]     wr_row;
  logic [NW-1:0]        din_nxt;
  logic [NW-1:0]        dout_nxt;
  logic [NW:0]          sum_nxt;
  logic                 walk_last;

  assign vc_ext  = CMPW'(vcount_q);
  assign max_ext = CMPW'(MAX_V);
  assign n_cur   = (vc_ext > max_ext) ? max_ext : vc_ext;
  assign src_ok  = CMPW'(src_vertex_i) < n_cur;
  assign dst_ok  = CMPW'(dst_vertex_i) < n_cur;

  assign src_idx  = IW'(src_q);
  assign dst_idx  = IW'(dst_q);
  assign edge_bit = rd_row[dst_idx];

  always_comb begin
    unique case (state_q)
      ST_IDLE: rd_addr = IW'(src_vertex_i);
      ST_ROW:  rd_addr = '0;
      ST_WALK: rd_addr = idx_q + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  assign wr_en = (state_q == ST_ROW) && ok_q &&
                 (((kind_q == KIND_INSERT) && !edge_bit) ||
                  ((kind_q == KIND_REMOVE) && edge_bit));
  assign wr_row = rd_row ^ (MAX_V'(1) << dst_idx);

  assign din_nxt   = din_q + NW'(rd_row[src_idx]);
  assign dout_nxt  = dout_q + NW'(row_q[idx_q]);
  assign sum_nxt   = {1'b0, din_nxt} + {1'b0, dout_nxt};
  assign walk_last = NW'(idx_q) == (n_q - 1'b1);

  dgam_row_mem #(
    .MAX_V(MAX_V)
  ) u_row_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_addr_i(src_idx),
    .wr_row_i (wr_row),
    .rd_addr_i(rd_addr),
    .rd_row_o (rd_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VcountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vcount_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      edge_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            kind_q  <= kind_e'(kind_i);
            src_q   <= src_vertex_i;
            dst_q   <= dst_vertex_i;
            n_q     <= NW'(n_cur);
            ok_q    <= src_ok && ((kind_e'(kind_i) == KIND_DEGREE) || dst_ok);
            state_q <= ST_ROW;
          end
        end
        ST_ROW: begin
          adj_q     <= 1'b0;
          in_deg_q  <= '0;
          out_deg_q <= '0;
          total_q   <= '0;
          status_q  <= STATUS_OK;
          if (!ok_q) begin
            status_q <= STATUS_INVALID;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            unique case (kind_q)
              KIND_INSERT: begin
                if (edge_bit) begin
                  status_q <= STATUS_EXISTS;
                end else begin
                  edge_q <= edge_q + 1'b1;
                end
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end
              KIND_REMOVE: begin
                if (!edge_bit) begin
                  status_q <= STATUS_ABSENT;
                end else begin
                  edge_q <= edge_q - 1'b1;
                end
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end
              KIND_QUERY: begin
                adj_q   <= edge_bit;
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end
              KIND_DEGREE: begin
                row_q   <= rd_row;
                idx_q   <= '0;
                din_q   <= '0;
                dout_q  <= '0;
                state_q <= ST_WALK;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_WALK: begin
          din_q  <= din_nxt;
          dout_q <= dout_nxt;
          idx_q  <= idx_q + 1'b1;
          if (walk_last) begin
            in_deg_q  <= DegW'(din_nxt);
            out_deg_q <= DegW'(dout_nxt);
            total_q   <= TotalW'(sum_nxt);
            done_q    <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o         = state_q != ST_IDLE;
  assign cfg_ready_o    = 1'b1;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign is_adjacent_o  = adj_q;
  assign in_degree_o    = in_deg_q;
  assign out_degree_o   = out_deg_q;
  assign total_degree_o = total_q;
  assign edge_count_o   = edge_q;

  `ASSERT_CLK(a_start_busy, (start_i && !busy_o) |=> busy_o, "transfer did not start work")
  `ASSERT_NEVER(a_done_idle, done_o && busy_o, "result shown while busy")
  `ASSERT_CLK(a_total_sum,
      done_o |-> (total_degree_o == ({1'b0, in_degree_o} + {1'b0, out_degree_o})),
      "total degree differs from in plus out")
  `ASSERT_CLK(a_invalid_zero,
      (done_o && (status_o == STATUS_INVALID)) |->
      (!is_adjacent_o && (in_degree_o == '0) && (out_degree_o == '0)),
      "invalid vertex result carries data")

endmodule

// ----- sv/dgam_row_mem.sv -----
module dgam_row_mem import dgam_pkg::*; #(
  parameter int MAX_V = DefMaxV,
  localparam int IW = $clog2(MAX_V)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IW-1:0]    wr_addr_i,
  input  logic [MAX_V-1:0] wr_row_i,
  input  logic [IW-1:0]    rd_addr_i,
  output logic [MAX_V-1:0] rd_row_o
);

  logic [MAX_V-1:0] mem_q [MAX_V];
  logic [MAX_V-1:0] rd_data_q;
  logic [MAX_V-1:0] vld_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  // rows never written since reset read as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_row_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dgam_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [KindW-1:0]   kind_i;
  logic [VertexW-1:0] src_vertex_i;
  logic [VertexW-1:0] dst_vertex_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [VcountW-1:0] cfg_data_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic               is_adjacent_o;
  logic [DegW-1:0]    in_degree_o;
  logic [DegW-1:0]    out_degree_o;
  logic [TotalW-1:0]  total_degree_o;
  logic [EdgeW-1:0]   edge_count_o;

  directed_graph_adjacency_matrix_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .src_vertex_i   (src_vertex_i),
    .dst_vertex_i   (dst_vertex_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .is_adjacent_o  (is_adjacent_o),
    .in_degree_o    (in_degree_o),
    .out_degree_o   (out_degree_o),
    .total_degree_o (total_degree_o),
    .edge_count_o   (edge_count_o)
  );

  typedef struct packed {
    status_e            status;
    logic               adj;
    logic [DegW-1:0]    din;
    logic [DegW-1:0]    dout;
    logic [TotalW-1:0]  tot;
    logic [EdgeW-1:0]   edges;
  } graph_result_t;

  typedef struct packed {
    logic               is_cfg;
    logic [VcountW-1:0] cfg_value;
    kind_e              kind;
    logic [VertexW-1:0] src;
    logic [VertexW-1:0] dst;
    logic               typed;
    status_e            st;
    logic               adj;
    logic [DegW-1:0]    din;
    logic [DegW-1:0]    dout;
    logic [TotalW-1:0]  tot;
    logic [EdgeW-1:0]   edges;
  } graph_row_t;

  localparam int NumRows = 29;

  // is_cfg, cfg, kind, src, dst, typed, status, adj, in, out, total, edges
  graph_row_t directed_rows [NumRows] = '{
    '{1'b0, 7'd0, KIND_DEGREE, 6'd0, 6'd0, 1'b1, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b0, 7'd0, KIND_QUERY, 6'd63, 6'd63, 1'b1, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b0, 7'd0, KIND_REMOVE, 6'd0, 6'd0, 1'b1, STATUS_ABSENT, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b0, 7'd0, KIND_INSERT, 6'd0, 6'd63, 1'b1, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd1},
    '{1'b0, 7'd0, KIND_INSERT, 6'd0, 6'd63, 1'b1, STATUS_EXISTS, 1'b0, 7'd0, 7'd0, 8'd0, 13'd1},
    '{1'b0, 7'd0, KIND_INSERT, 6'd63, 6'd0, 1'b1, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd2},
    '{1'b0, 7'd0, KIND_INSERT, 6'd63, 6'd63, 1'b1, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd3},
    '{1'b0, 7'd0, KIND_QUERY, 6'd0, 6'd63, 1'b1, STATUS_OK, 1'b1, 7'd0, 7'd0, 8'd0, 13'd3},
    '{1'b0, 7'd0, KIND_DEGREE, 6'd63, 6'd5, 1'b0, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b0, 7'd0, KIND_DEGREE, 6'd0, 6'd63, 1'b0, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b0, 7'd0, KIND_REMOVE, 6'd0, 6'd63, 1'b1, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd2},
    '{1'b1, 7'd1, KIND_INSERT, 6'd0, 6'd0, 1'b0, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b0, 7'd0, KIND_INSERT, 6'd0, 6'd0, 1'b1, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd3},
    '{1'b0, 7'd0, KIND_INSERT, 6'd0, 6'd1, 1'b1, STATUS_INVALID, 1'b0, 7'd0, 7'd0, 8'd0, 13'd3},
    '{1'b0, 7'd0, KIND_QUERY, 6'd1, 6'd0, 1'b1, STATUS_INVALID, 1'b0, 7'd0, 7'd0, 8'd0, 13'd3},
    '{1'b0, 7'd0, KIND_DEGREE, 6'd1, 6'd0, 1'b1, STATUS_INVALID, 1'b0, 7'd0, 7'd0, 8'd0, 13'd3},
    '{1'b0, 7'd0, KIND_DEGREE, 6'd0, 6'd42, 1'b0, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b1, 7'd0, KIND_INSERT, 6'd0, 6'd0, 1'b0, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b0, 7'd0, KIND_INSERT, 6'd0, 6'd0, 1'b1, STATUS_INVALID, 1'b0, 7'd0, 7'd0, 8'd0, 13'd3},
    '{1'b0, 7'd0, KIND_DEGREE, 6'd0, 6'd0, 1'b1, STATUS_INVALID, 1'b0, 7'd0, 7'd0, 8'd0, 13'd3},
    '{1'b1, 7'd127, KIND_INSERT, 6'd0, 6'd0, 1'b0, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b0, 7'd0, KIND_QUERY, 6'd63, 6'd63, 1'b0, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b0, 7'd0, KIND_DEGREE, 6'd63, 6'd21, 1'b0, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b1, 7'd32, KIND_INSERT, 6'd0, 6'd0, 1'b0, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b0, 7'd0, KIND_REMOVE, 6'd63, 6'd0, 1'b1, STATUS_INVALID, 1'b0, 7'd0, 7'd0, 8'd0, 13'd3},
    '{1'b0, 7'd0, KIND_DEGREE, 6'd63, 6'd0, 1'b1, STATUS_INVALID, 1'b0, 7'd0, 7'd0, 8'd0, 13'd3},
    '{1'b0, 7'd0, KIND_DEGREE, 6'd0, 6'd0, 1'b0, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b0, 7'd0, KIND_INSERT, 6'd31, 6'd31, 1'b0, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0},
    '{1'b1, 7'd64, KIND_INSERT, 6'd0, 6'd0, 1'b0, STATUS_OK, 1'b0, 7'd0, 7'd0, 8'd0, 13'd0}
  };

  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 65;

  // graph state as the block should hold it
  bit [DefMaxV-1:0]   graph_rows [DefMaxV];
  logic [EdgeW-1:0]   graph_edges;
  logic [VcountW-1:0] graph_vcount;

  graph_result_t pending_results [$];
  bit [11:0]     live_pairs [$];
  int            mismatches;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic graph_result_t apply_graph_op(kind_e k, bit [5:0] s, bit [5:0] d);
    graph_result_t r;
    int n;
    int din;
    int dout;
    n = (graph_vcount > DefMaxV) ? DefMaxV : int'(graph_vcount);
    din = 0;
    dout = 0;
    r.status = STATUS_OK;
    r.adj = 1'b0;
    if (k == KIND_DEGREE) begin
      if (int'(s) >= n) begin
        r.status = STATUS_INVALID;
      end else begin
        for (int i = 0; i < n; i++) begin
          din += graph_rows[i][s];
          dout += graph_rows[s][i];
        end
      end
    end else if (int'(s) >= n || int'(d) >= n) begin
      r.status = STATUS_INVALID;
    end else if (k == KIND_INSERT) begin
      if (graph_rows[s][d]) begin
        r.status = STATUS_EXISTS;
      end else begin
        graph_rows[s][d] = 1'b1;
        graph_edges = graph_edges + 1'b1;
      end
    end else if (k == KIND_REMOVE) begin
      if (!graph_rows[s][d]) begin
        r.status = STATUS_ABSENT;
      end else begin
        graph_rows[s][d] = 1'b0;
        graph_edges = graph_edges - 1'b1;
      end
    end else begin
      r.adj = graph_rows[s][d];
    end
    r.din = din[DegW-1:0];
    r.dout = dout[DegW-1:0];
    r.tot = TotalW'(din + dout);
    r.edges = graph_edges;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit [5:0] pick_vertex(int n);
    if (n == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, n - 1));
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch in %s: got %0d, want %0d", what, got, want);
  endtask

  // called right after a rising edge; returns right after the transfer edge or the gap
  task automatic send_op(kind_e k, bit [5:0] s, bit [5:0] d, bit typed,
                         graph_result_t hand, int gap);
    graph_result_t pred;
    start_i <= 1'b1;
    kind_i <= k;
    src_vertex_i <= s;
    dst_vertex_i <= d;
    do @(posedge clk_i); while (busy_o);
    pred = apply_graph_op(k, s, d);
    pending_results.push_back(typed ? hand : pred);
    if (k == KIND_INSERT && pred.status == STATUS_OK) begin
      live_pairs.push_back({s, d});
      if (live_pairs.size() > 256) void'(live_pairs.pop_front());
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_vcount(logic [VcountW-1:0] v);
    start_i <= 1'b0;
    while (pending_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    graph_vcount = v;
  endtask

  always @(posedge clk_i) begin
    graph_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", int'(status_o), 0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) flag_mismatch("status", status_o, want.status);
        if (is_adjacent_o !== want.adj) flag_mismatch("is_adjacent", is_adjacent_o, want.adj);
        if (in_degree_o !== want.din) flag_mismatch("in_degree", in_degree_o, want.din);
        if (out_degree_o !== want.dout) flag_mismatch("out_degree", out_degree_o, want.dout);
        if (total_degree_o !== want.tot) flag_mismatch("total_degree", total_degree_o, want.tot);
        if (edge_count_o !== want.edges) flag_mismatch("edge_count", edge_count_o, want.edges);
      end
    end
  end

  initial begin
    graph_result_t hand;
    graph_row_t row;
    int phase_vcount [NumPhases];
    bit no_gaps;
    int n_use;
    int r;
    kind_e k;
    bit [5:0] s;
    bit [5:0] d;
    bit [11:0] pair;

    phase_vcount = '{64, 4, 127, 2, 0, 16, 1, 64, 33, 65};
    phase_vcount[NumPhases-1] = $urandom_range(1, 127);
    foreach (graph_rows[i]) graph_rows[i] = '0;
    graph_edges = '0;
    graph_vcount = VcountReset;
    mismatches = 0;

    rst_ni <= 1'b0;
    start_i <= 1'b0;
    kind_i <= KIND_INSERT;
    src_vertex_i <= '0;
    dst_vertex_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        write_vcount(row.cfg_value);
      end else begin
        hand.status = row.st;
        hand.adj = row.adj;
        hand.din = row.din;
        hand.dout = row.dout;
        hand.tot = row.tot;
        hand.edges = row.edges;
        send_op(row.kind, row.src, row.dst, row.typed, hand, pick_gap());
      end
    end

    hand = '0;
    for (int p = 0; p < NumPhases; p++) begin
      write_vcount(VcountW'(phase_vcount[p]));
      n_use = (graph_vcount > DefMaxV) ? DefMaxV : int'(graph_vcount);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < ItemsPerPhase; j++) begin
        r = $urandom_range(0, 99);
        k = (r < 40) ? KIND_INSERT : (r < 62) ? KIND_REMOVE :
            (r < 80) ? KIND_QUERY : KIND_DEGREE;
        s = pick_vertex(n_use);
        d = pick_vertex(n_use);
        // revisit stored edges so removals and queries hit
        if ((k == KIND_REMOVE || k == KIND_QUERY) && live_pairs.size() != 0 &&
            $urandom_range(0, 1) == 1) begin
          pair = live_pairs[$urandom_range(0, live_pairs.size() - 1)];
          s = pair[11:6];
          d = pair[5:0];
        end
        send_op(k, s, d, 1'b0, hand, no_gaps ? 0 : pick_gap());
      end
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
